// ----- design/signal_phase_sequencer_defines.svh -----
// ----------------------------------------------------------------------------
// signal phase sequencer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SIGNAL_PHASE_SEQUENCER_DEFINES_SVH
`define SIGNAL_PHASE_SEQUENCER_DEFINES_SVH

// same-cycle implication, reset disables the check
`define SPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset disables the check
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// types, codes and default sizes for the signal phase sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sps_pkg;

    // default sizes
    localparam int MAX_PHASES_DEF = 8;
    localparam int APPROACHES_DEF = 8;
    localparam int TIME_WIDTH_DEF = 16;

    // fixed field widths
    localparam int FIELD_TIME_W = 16;
    localparam int SLOT_W       = 3;
    localparam int MASK_W       = 8;
    localparam int STATES_W     = 16;
    localparam int PHASE_OUT_W  = 3;
    localparam int COUNT_W      = 4;
    localparam int PADDR_W      = 3;
    localparam int APB_DATA_W   = 32;

    // lamp codes, two bits per approach
    typedef enum logic [1:0] {
        LAMP_OFF    = 2'd0,
        LAMP_RED    = 2'd1,
        LAMP_YELLOW = 2'd2,
        LAMP_GREEN  = 2'd3
    } t_lamp;

    // input word kinds
    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_LOAD = 1'b1
    } t_mode;

    // configuration register index (paddr bit 2)
    typedef enum logic {
        REG_SIGNALS_ENABLED = 1'b0,
        REG_PHASE_COUNT     = 1'b1
    } t_reg_idx;

    // input word
    typedef struct packed {
        logic                    mode;
        logic [FIELD_TIME_W-1:0] delta_ticks;
        logic [SLOT_W-1:0]       phase_slot;
        logic [FIELD_TIME_W-1:0] green_time;
        logic [FIELD_TIME_W-1:0] clearance_time;
        logic [MASK_W-1:0]       green_mask;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [STATES_W-1:0]    approach_states;
        logic [PHASE_OUT_W-1:0] active_phase;
        logic                   in_clearance;
    } t_out_word;

    // configuration seen by the sequencing logic
    typedef struct packed {
        logic               signals_enabled;
        logic [COUNT_W-1:0] phase_count;
    } t_seq_cfg;

    // phase table write control
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] slot;
    } t_tbl_wr;

endpackage

// ----- design/sps_table.sv -----
// ----------------------------------------------------------------------------
// sps_table
// phase table: green time, clearance time and green mask per phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sps_table #(
    parameter int MAX_PHASES = sps_pkg::MAX_PHASES_DEF,
    parameter int TIME_WIDTH = sps_pkg::TIME_WIDTH_DEF,
    localparam int PIW       = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1
) (
    input  logic                      i_clk,
    input  sps_pkg::t_tbl_wr          i_wr,
    input  logic [TIME_WIDTH-1:0]     i_green,
    input  logic [TIME_WIDTH-1:0]     i_clear,
    input  logic [sps_pkg::MASK_W-1:0] i_mask,
    input  logic [PIW-1:0]            i_time_idx,
    input  logic [PIW-1:0]            i_mask_idx,
    output logic [TIME_WIDTH-1:0]     o_green,
    output logic [TIME_WIDTH-1:0]     o_clear,
    output logic [sps_pkg::MASK_W-1:0] o_mask
);

    // only slots reachable through the slot field are stored
    localparam int TD  = (MAX_PHASES < (1 << sps_pkg::SLOT_W)) ? MAX_PHASES
                                                               : (1 << sps_pkg::SLOT_W);
    localparam int TIW = (TD > 1) ? $clog2(TD) : 1;

    logic [TIME_WIDTH-1:0]      r_green_times     [TD];
    logic [TIME_WIDTH-1:0]      r_clearance_times [TD];
    logic [sps_pkg::MASK_W-1:0] r_green_masks     [TD];

    // entry write, slots past the table are dropped
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en && (int'(i_wr.slot) < TD)) begin
            r_green_times[i_wr.slot[TIW-1:0]]     <= i_green;
            r_clearance_times[i_wr.slot[TIW-1:0]] <= i_clear;
            r_green_masks[i_wr.slot[TIW-1:0]]     <= i_mask;
        end
    end

    // times at the running phase, mask at the phase after the step
    assign o_green = (int'(i_time_idx) < TD) ? r_green_times[i_time_idx[TIW-1:0]] : '0;
    assign o_clear = (int'(i_time_idx) < TD) ? r_clearance_times[i_time_idx[TIW-1:0]] : '0;
    assign o_mask  = (int'(i_mask_idx) < TD) ? r_green_masks[i_mask_idx[TIW-1:0]] : '0;

endmodule

// ----- design/sps_seq.sv -----
// ----------------------------------------------------------------------------
// sps_seq
// phase state registers, one-step update and lamp word generation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sps_seq #(
    parameter int MAX_PHASES = sps_pkg::MAX_PHASES_DEF,
    parameter int APPROACHES = sps_pkg::APPROACHES_DEF,
    parameter int TIME_WIDTH = sps_pkg::TIME_WIDTH_DEF,
    localparam int PIW       = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  sps_pkg::t_seq_cfg          i_cfg,
    input  sps_pkg::t_in_word          i_word,
    output logic [PIW-1:0]             o_time_idx,
    output logic [PIW-1:0]             o_mask_idx,
    input  logic [TIME_WIDTH-1:0]      i_green,
    input  logic [TIME_WIDTH-1:0]      i_clear,
    input  logic [sps_pkg::MASK_W-1:0] i_mask,
    output sps_pkg::t_out_word         o_result
);

    localparam int CW  = (PIW + 1 > sps_pkg::COUNT_W) ? PIW + 1 : sps_pkg::COUNT_W;
    localparam int EW  = TIME_WIDTH + 1;
    localparam int LA  = (APPROACHES < sps_pkg::MASK_W) ? APPROACHES : sps_pkg::MASK_W;

    logic [PIW-1:0] r_phase;
    logic [EW-1:0]  r_elapsed;
    logic           r_clearing;

    logic [PIW-1:0] n_phase;
    logic [EW-1:0]  n_elapsed;
    logic           n_clearing;

    logic [CW-1:0]              w_used;
    logic                       w_active;
    logic                       w_snap;
    logic [PIW-1:0]             w_eff_phase;
    logic [EW-1:0]              w_eff_elapsed;
    logic                       w_eff_clearing;
    logic [CW-1:0]              w_inc;
    logic [PIW-1:0]             w_next_phase;
    logic [EW:0]                w_sum;
    logic [EW-1:0]              w_sat;
    logic [sps_pkg::MASK_W-1:0] w_lamp_mask;
    logic [sps_pkg::STATES_W-1:0] w_states;
    sps_pkg::t_lamp             w_code;

    // phases in use, held to the table size
    assign w_used = (CW'(i_cfg.phase_count) > CW'(MAX_PHASES)) ? CW'(MAX_PHASES)
                                                               : CW'(i_cfg.phase_count);
    assign w_active = i_cfg.signals_enabled && (w_used != '0);

    // out-of-range phase snaps back to phase 0, green
    assign w_snap         = (CW'(r_phase) >= w_used);
    assign w_eff_phase    = w_snap ? '0 : r_phase;
    assign w_eff_elapsed  = w_snap ? '0 : r_elapsed;
    assign w_eff_clearing = w_snap ? 1'b0 : r_clearing;

    // wrap to phase 0 after the last phase in use
    assign w_inc        = CW'(w_eff_phase) + CW'(1);
    assign w_next_phase = (w_inc >= w_used) ? '0 : w_inc[PIW-1:0];

    // elapsed time plus delta, saturating
    assign w_sum = (EW+1)'(w_eff_elapsed) + (EW+1)'(TIME_WIDTH'(i_word.delta_ticks));
    assign w_sat = w_sum[EW] ? '1 : w_sum[EW-1:0];

    assign o_time_idx = w_eff_phase;

    // next state, at most one transition
    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_clearing = r_clearing;
        if (i_word.mode == sps_pkg::MODE_LOAD) begin
            n_phase    = '0;
            n_elapsed  = '0;
            n_clearing = 1'b0;
        end else if (w_active) begin
            n_phase    = w_eff_phase;
            n_elapsed  = w_sat;
            n_clearing = w_eff_clearing;
            if (!w_eff_clearing) begin
                if (w_sat >= EW'(i_green)) begin
                    n_clearing = 1'b1;
                    n_elapsed  = '0;
                end
            end else if (w_sat >= EW'(i_clear)) begin
                n_phase    = w_next_phase;
                n_elapsed  = '0;
                n_clearing = 1'b0;
            end
        end
    end

    assign o_mask_idx = n_phase;

    // a load to slot 0 supplies the mask of the restarted phase
    assign w_lamp_mask = ((i_word.mode == sps_pkg::MODE_LOAD) && (i_word.phase_slot == '0))
                       ? i_word.green_mask : i_mask;

    // lamp code per approach
    always_comb begin
        w_states = '0;
        w_code   = sps_pkg::LAMP_OFF;
        if (w_active) begin
            for (int a = 0; a < LA; a++) begin
                if (CW'(n_phase) >= w_used) begin
                    w_code = sps_pkg::LAMP_RED;
                end else if (w_lamp_mask[a]) begin
                    w_code = n_clearing ? sps_pkg::LAMP_YELLOW : sps_pkg::LAMP_GREEN;
                end else begin
                    w_code = sps_pkg::LAMP_RED;
                end
                w_states[2*a +: 2] = w_code;
            end
        end
    end

    assign o_result.approach_states = w_states;
    assign o_result.active_phase    = sps_pkg::PHASE_OUT_W'(n_phase);
    assign o_result.in_clearance    = n_clearing;

    // state commit when a word passes to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_elapsed  <= '0;
            r_clearing <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_elapsed  <= n_elapsed;
            r_clearing <= n_clearing;
        end
    end

endmodule

// ----- design/signal_phase_sequencer.sv -----
// ----------------------------------------------------------------------------
// signal_phase_sequencer
// traffic signal phase sequencer with a loadable phase table
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_word): a tick word adds
// delta_ticks to the running interval, a load word writes one phase table
// entry and restarts at phase 0, green. Every accepted word gives exactly one
// result word on the output channel (o_out_valid / i_out_stall / o_out_word)
// holding the lamp states, phase and clearance flag after that word.
// Words pass through the input register, then the result register. Throughput:
// one word per cycle while the result is not stalled; the whole update (one
// add, two compares, the phase wrap and the lamp word) is a single
// combinational pass between the two registers.
// Stalls: while the result is stalled the block still takes one more word
// into its input register, then raises o_in_stall until the result is taken.
// Reset (i_rst_n low, synchronous) clears both valid flags, the phase state
// and the APB registers (signals disabled, no phases); table contents are
// kept. APB writes are expected only while no word is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signal_phase_sequencer #(
    parameter int MAX_PHASES = sps_pkg::MAX_PHASES_DEF,
    parameter int APPROACHES = sps_pkg::APPROACHES_DEF,
    parameter int TIME_WIDTH = sps_pkg::TIME_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sps_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sps_pkg::t_out_word             o_out_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sps_pkg::PADDR_W-1:0]    paddr,
    input  logic [sps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sps_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int PIW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;

    logic                            r_signals_enabled;
    logic [sps_pkg::COUNT_W-1:0]     r_phase_count;
    logic                            r_in_valid;
    sps_pkg::t_in_word               r_in_word;
    logic                            r_out_valid;
    sps_pkg::t_out_word              r_out_word;

    logic                            w_out_free;
    logic                            w_step;
    sps_pkg::t_reg_idx               w_reg_idx;
    sps_pkg::t_seq_cfg               w_cfg;
    sps_pkg::t_tbl_wr                w_tbl_wr;
    sps_pkg::t_out_word              w_result;
    logic [PIW-1:0]                  w_time_idx;
    logic [PIW-1:0]                  w_mask_idx;
    logic [TIME_WIDTH-1:0]           w_green;
    logic [TIME_WIDTH-1:0]           w_clear;
    logic [sps_pkg::MASK_W-1:0]      w_mask;

    // apb register file
    assign pready    = 1'b1;
    assign w_reg_idx = sps_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signals_enabled <= 1'b0;
            r_phase_count     <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg_idx)
                sps_pkg::REG_SIGNALS_ENABLED: begin
                    r_signals_enabled <= pwdata[0];
                end
                sps_pkg::REG_PHASE_COUNT: begin
                    r_phase_count <= pwdata[sps_pkg::COUNT_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            sps_pkg::REG_SIGNALS_ENABLED: begin
                prdata = sps_pkg::APB_DATA_W'(r_signals_enabled);
            end
            sps_pkg::REG_PHASE_COUNT: begin
                prdata = sps_pkg::APB_DATA_W'(r_phase_count);
            end
        endcase
    end

    // handshake: the result register frees when empty or taken
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // phase table and sequencing
    assign w_cfg.signals_enabled = r_signals_enabled;
    assign w_cfg.phase_count     = r_phase_count;
    assign w_tbl_wr.wr_en        = w_step && (r_in_word.mode == sps_pkg::MODE_LOAD);
    assign w_tbl_wr.slot         = r_in_word.phase_slot;

    sps_table #(
        .MAX_PHASES (MAX_PHASES),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr       (w_tbl_wr),
        .i_green    (TIME_WIDTH'(r_in_word.green_time)),
        .i_clear    (TIME_WIDTH'(r_in_word.clearance_time)),
        .i_mask     (r_in_word.green_mask),
        .i_time_idx (w_time_idx),
        .i_mask_idx (w_mask_idx),
        .o_green    (w_green),
        .o_clear    (w_clear),
        .o_mask     (w_mask)
    );

    sps_seq #(
        .MAX_PHASES (MAX_PHASES),
        .APPROACHES (APPROACHES),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_cfg      (w_cfg),
        .i_word     (r_in_word),
        .o_time_idx (w_time_idx),
        .o_mask_idx (w_mask_idx),
        .i_green    (w_green),
        .i_clear    (w_clear),
        .i_mask     (w_mask),
        .o_result   (w_result)
    );

endmodule

// ----- design/sps_checker.sv -----
// ----------------------------------------------------------------------------
// sps_checker
// port-level checks on the signal phase sequencer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signal_phase_sequencer_defines.svh"

module sps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_stall,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input sps_pkg::t_out_word i_out_word
);

    logic [sps_pkg::STATES_W-1:0] w_any_green;
    logic [sps_pkg::STATES_W-1:0] w_any_yellow;

    // per-approach green and yellow flags on the even bit positions
    assign w_any_green  = (i_out_word.approach_states >> 1) & i_out_word.approach_states
                        & 16'h5555;
    assign w_any_yellow = (i_out_word.approach_states >> 1) & ~i_out_word.approach_states
                        & 16'h5555;

    // stalled result word holds
    `SPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_word), "stalled result word changed")

    // every accepted word is followed by a valid result word
    `SPS_ASSERT_IMP(a_latency, i_clk, i_rst_n, i_in_valid && !i_in_stall, ##2 i_out_valid, "result missing two cycles after accept")

    // clearance shows no green
    `SPS_ASSERT_IMP(a_clear_no_green, i_clk, i_rst_n, i_out_valid && i_out_word.in_clearance, w_any_green == '0, "green shown during clearance")

    // green interval shows no yellow
    `SPS_ASSERT_IMP(a_green_no_yellow, i_clk, i_rst_n, i_out_valid && !i_out_word.in_clearance, w_any_yellow == '0, "yellow shown outside clearance")

endmodule

bind signal_phase_sequencer sps_checker u_sps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_word  (o_out_word)
);

// ----- bench/signal_phase_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// signal_phase_sequencer_tb
// self-checking bench for the traffic signal phase sequencer: a directed
// table loads the phase table and walks the corner cases, then randomised
// tick and load traffic runs under a series of register settings, with every
// result word checked against the expected word given in its table row or
// against a local model of the phase sequencing
`timescale 1ns / 1ps

module signal_phase_sequencer_tb;

    localparam int          PHASES      = sps_pkg::MAX_PHASES_DEF;
    localparam logic [16:0] ELAPSED_TOP = 17'h1FFFF;
    localparam int          RAND_SETS   = 12;
    localparam int          SET_WORDS   = 158;

    // clock, reset and block ports
    logic                        i_clk;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    sps_pkg::t_in_word           i_in_word   = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    sps_pkg::t_out_word          o_out_word;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [sps_pkg::PADDR_W-1:0] paddr       = '0;
    logic [31:0]                 pwdata      = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // one line of the directed stimulus table
    typedef struct {
        bit                 is_cfg;
        sps_pkg::t_reg_idx  sel;
        logic [31:0]        value;
        sps_pkg::t_in_word  word;
        bit                 typed;
        sps_pkg::t_out_word want;
    } t_script_row;

    // local copy of the phase table, sequencing state and registers
    logic [15:0] plan_green [PHASES];
    logic [15:0] plan_clear [PHASES];
    logic [7:0]  plan_mask  [PHASES];
    logic [2:0]  cur_phase    = '0;
    logic [16:0] cur_elapsed  = '0;
    logic        cur_clearing = 1'b0;
    logic        cfg_enabled  = 1'b0;
    logic [3:0]  cfg_count    = '0;

    sps_pkg::t_out_word pending_lamps [$];
    t_script_row script [$];

    int errors       = 0;
    int words_sent   = 0;
    int loads_sent   = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int phase_steps  = 0;
    int snaps        = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    int stall_left   = 0;

    signal_phase_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("signal_phase_sequencer_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    // sequencing model: applies one word, returns the result word after it
    function automatic sps_pkg::t_out_word step_signal_plan(input sps_pkg::t_in_word w);
        logic [3:0]         n;
        logic [3:0]         nxt;
        logic [17:0]        sum;
        logic [1:0]         code;
        sps_pkg::t_out_word r;
        n = (cfg_count > PHASES) ? 4'(PHASES) : cfg_count;
        if (w.mode == sps_pkg::MODE_TICK) begin
            if (cfg_enabled && n != 0) begin
                // phase left beyond the table after a count change
                if ({1'b0, cur_phase} >= n) begin
                    cur_phase    = '0;
                    cur_elapsed  = '0;
                    cur_clearing = 1'b0;
                    snaps++;
                end
                sum = cur_elapsed + w.delta_ticks;
                cur_elapsed = (sum > ELAPSED_TOP) ? ELAPSED_TOP : sum[16:0];
                if (!cur_clearing) begin
                    if (cur_elapsed >= plan_green[cur_phase]) begin
                        cur_clearing = 1'b1;
                        cur_elapsed  = '0;
                    end
                end else if (cur_elapsed >= plan_clear[cur_phase]) begin
                    nxt          = {1'b0, cur_phase} + 4'd1;
                    cur_phase    = (nxt >= n) ? 3'd0 : nxt[2:0];
                    cur_elapsed  = '0;
                    cur_clearing = 1'b0;
                    phase_steps++;
                end
            end
        end else begin
            // table write, then restart from phase 0 green
            plan_green[w.phase_slot] = w.green_time;
            plan_clear[w.phase_slot] = w.clearance_time;
            plan_mask[w.phase_slot]  = w.green_mask;
            cur_phase    = '0;
            cur_elapsed  = '0;
            cur_clearing = 1'b0;
        end
        // lamp word
        r.approach_states = '0;
        if (cfg_enabled && n != 0) begin
            for (int a = 0; a < sps_pkg::APPROACHES_DEF; a++) begin
                if ({1'b0, cur_phase} >= n) begin
                    code = sps_pkg::LAMP_RED;
                end else if (plan_mask[cur_phase][a]) begin
                    code = cur_clearing ? sps_pkg::LAMP_YELLOW : sps_pkg::LAMP_GREEN;
                end else begin
                    code = sps_pkg::LAMP_RED;
                end
                r.approach_states[2*a +: 2] = code;
            end
        end
        r.active_phase = cur_phase;
        r.in_clearance = cur_clearing;
        return r;
    endfunction

    function automatic sps_pkg::t_in_word tick_word(input logic [15:0] delta);
        sps_pkg::t_in_word w;
        w = sps_pkg::t_in_word'({$urandom, $urandom, $urandom});
        w.mode        = sps_pkg::MODE_TICK;
        w.delta_ticks = delta;
        return w;
    endfunction

    function automatic sps_pkg::t_in_word load_word(input logic [2:0] slot,
                                                    input logic [15:0] g,
                                                    input logic [15:0] c,
                                                    input logic [7:0] m);
        sps_pkg::t_in_word w;
        w = sps_pkg::t_in_word'({$urandom, $urandom, $urandom});
        w.mode           = sps_pkg::MODE_LOAD;
        w.phase_slot     = slot;
        w.green_time     = g;
        w.clearance_time = c;
        w.green_mask     = m;
        return w;
    endfunction

    function automatic sps_pkg::t_out_word lamps(input logic [15:0] states,
                                                 input logic [2:0] ph, input logic clr);
        sps_pkg::t_out_word r;
        r.approach_states = states;
        r.active_phase    = ph;
        r.in_clearance    = clr;
        return r;
    endfunction

    function automatic t_script_row cfg_row(input sps_pkg::t_reg_idx sel,
                                            input logic [31:0] v);
        t_script_row r;
        r.is_cfg = 1'b1;
        r.sel    = sel;
        r.value  = v;
        r.word   = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_script_row word_row(input sps_pkg::t_in_word w, input bit typed,
                                             input sps_pkg::t_out_word want);
        t_script_row r;
        r.is_cfg = 1'b0;
        r.sel    = sps_pkg::REG_SIGNALS_ENABLED;
        r.value  = '0;
        r.word   = w;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    // durations: mostly short so phases cycle, sometimes anything
    function automatic logic [15:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, 40));
        if (r < 90) return 16'($urandom_range(0, 1000));
        if (r < 95) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic sps_pkg::t_in_word random_word();
        int r;
        logic [15:0] delta;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            return load_word(3'($urandom), pick_time(), pick_time(), 8'($urandom));
        end
        r = $urandom_range(0, 99);
        if (r < 60)      delta = 16'($urandom_range(0, 8));
        else if (r < 85) delta = 16'($urandom_range(0, 100));
        else             delta = 16'($urandom);
        return tick_word(delta);
    endfunction

    // offer one word, wait for acceptance, queue what it should produce
    task automatic send_word(input sps_pkg::t_in_word w, input bit typed,
                             input sps_pkg::t_out_word want);
        sps_pkg::t_out_word predicted;
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        predicted = step_signal_plan(w);
        pending_lamps.push_back(typed ? want : predicted);
        words_sent++;
        if (w.mode == sps_pkg::MODE_LOAD) loads_sent++;
    endtask

    // stop offering words and wait for every result to come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_lamps.size() != 0) @(posedge i_clk);
    endtask

    // register write then read-back, then idle
    task automatic write_reg(input sps_pkg::t_reg_idx sel, input logic [31:0] v);
        logic [31:0] want;
        want = (sel == sps_pkg::REG_SIGNALS_ENABLED) ? {31'b0, v[0]} : {28'b0, v[3:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == sps_pkg::REG_SIGNALS_ENABLED) cfg_enabled = v[0];
        else                                     cfg_count   = v[3:0];
        cfg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) report_mismatch("register read-back", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver stall bursts
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!rx_idle_on) begin
                stall_left = 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        sps_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_lamps.size() == 0) begin
                report_mismatch("result with none pending", 32'(o_out_word), '0);
            end else begin
                want = pending_lamps.pop_front();
                results_seen++;
                if (o_out_word.approach_states !== want.approach_states)
                    report_mismatch("approach_states", 32'(o_out_word.approach_states),
                                    32'(want.approach_states));
                if (o_out_word.active_phase !== want.active_phase)
                    report_mismatch("active_phase", 32'(o_out_word.active_phase),
                                    32'(want.active_phase));
                if (o_out_word.in_clearance !== want.in_clearance)
                    report_mismatch("in_clearance", 32'(o_out_word.in_clearance),
                                    32'(want.in_clearance));
            end
        end
    end

    initial begin
        sps_pkg::t_out_word dark;
        logic [3:0] count_pick;
        dark = lamps(16'h0000, 3'd0, 1'b0);
        foreach (plan_green[i]) begin
            plan_green[i] = '0;
            plan_clear[i] = '0;
            plan_mask[i]  = '0;
        end

        // hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: fill every slot while disabled, then the corners
        script.push_back(word_row(load_word(3'd0, 16'd0, 16'd0, 8'hFF), 1, dark));
        script.push_back(word_row(tick_word(16'hFFFF), 1, dark));
        script.push_back(word_row(load_word(3'd1, 16'd3, 16'd2, 8'h11), 1, dark));
        script.push_back(word_row(load_word(3'd2, 16'd1, 16'd1, 8'h22), 1, dark));
        script.push_back(word_row(load_word(3'd3, 16'd10, 16'd0, 8'h0F), 1, dark));
        script.push_back(word_row(load_word(3'd4, 16'd0, 16'd5, 8'hF0), 1, dark));
        script.push_back(word_row(load_word(3'd5, 16'd7, 16'd7, 8'h55), 1, dark));
        script.push_back(word_row(load_word(3'd6, 16'd2, 16'd9, 8'hAA), 1, dark));
        script.push_back(word_row(load_word(3'd7, 16'hFFFF, 16'hFFFF, 8'h00), 1, dark));
        // enabled but no phases: still all off
        script.push_back(cfg_row(sps_pkg::REG_SIGNALS_ENABLED, 32'd1));
        script.push_back(word_row(tick_word(16'd5), 1, dark));
        // count above the table size saturates
        script.push_back(cfg_row(sps_pkg::REG_PHASE_COUNT, 32'd15));
        script.push_back(word_row(load_word(3'd0, 16'd0, 16'd0, 8'hFF), 1,
                                  lamps(16'hFFFF, 3'd0, 1'b0)));
        script.push_back(word_row(tick_word(16'd0), 1, lamps(16'hAAAA, 3'd0, 1'b1)));
        // full-scale ticks expire every interval
        repeat (9) script.push_back(word_row(tick_word(16'hFFFF), 0, dark));
        // shrink the count under the running phase: snap back to phase 0
        script.push_back(cfg_row(sps_pkg::REG_PHASE_COUNT, 32'd3));
        script.push_back(word_row(tick_word(16'd1), 0, dark));
        script.push_back(cfg_row(sps_pkg::REG_PHASE_COUNT, 32'd8));
        script.push_back(word_row(load_word(3'd7, 16'hFFFF, 16'hFFFF, 8'h81), 0, dark));
        script.push_back(word_row(tick_word(16'd0), 0, dark));

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                settle();
                write_reg(script[i].sel, script[i].value);
            end else begin
                send_word(script[i].word, script[i].typed, script[i].want);
            end
        end

        // random traffic under a run of register settings
        for (int p = 0; p < RAND_SETS; p++) begin
            settle();
            tx_idle_on = (p != RAND_SETS - 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (p != RAND_SETS - 1) && ($urandom_range(0, 3) != 0);
            unique case (p)
                0: begin
                    write_reg(sps_pkg::REG_SIGNALS_ENABLED, 32'd1);
                    count_pick = 4'd8;
                end
                1: begin
                    write_reg(sps_pkg::REG_SIGNALS_ENABLED, 32'd1);
                    count_pick = 4'd1;
                end
                2: begin
                    write_reg(sps_pkg::REG_SIGNALS_ENABLED, 32'd0);
                    count_pick = 4'd5;
                end
                3: begin
                    write_reg(sps_pkg::REG_SIGNALS_ENABLED, 32'd1);
                    count_pick = 4'd0;
                end
                4: begin
                    write_reg(sps_pkg::REG_SIGNALS_ENABLED, 32'hFFFF_FFFF);
                    count_pick = 4'd15;
                end
                default: begin
                    write_reg(sps_pkg::REG_SIGNALS_ENABLED,
                              32'({$urandom_range(0, 7), 1'b0})
                              | 32'($urandom_range(0, 5) != 0));
                    count_pick = ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                             : 4'($urandom_range(1, 8));
                end
            endcase
            write_reg(sps_pkg::REG_PHASE_COUNT,
                      32'({$urandom_range(0, 255), count_pick[3:0]}) & 32'hFFF);
            for (int k = 0; k < SET_WORDS; k++) begin
                send_word(random_word(), 0, dark);
            end
        end

        // drain and look for stray results
        settle();
        repeat (10) @(posedge i_clk);
        if (pending_lamps.size() != 0)
            report_mismatch("results never arrived", 32'(pending_lamps.size()), '0);

        $display("%0d words driven (%0d loads, %0d ticks), %0d register writes, %0d results",
                 words_sent, loads_sent, words_sent - loads_sent, cfg_writes, results_seen);
        $display("model saw %0d phase changes and %0d snaps back from an out-of-range phase",
                 phase_steps, snaps);
        if (errors == 0) begin
            $display("signal_phase_sequencer_tb: clean");
        end else begin
            $display("signal_phase_sequencer_tb: errors");
        end
        $finish;
    end

endmodule
